>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/dget_pkg.sv
// ----------------------------------------------------------------------------
// Edge table package
// Field widths, operation and status codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dget_pkg;

    // Fixed widths of the channel fields.
    localparam int MODE_W   = 3;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;

    // Operation codes carried in the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_NODE     = 3'd0,
        MODE_REMOVE_NODE  = 3'd1,
        MODE_ADD_EDGE     = 3'd2,
        MODE_REMOVE_EDGE  = 3'd3,
        MODE_LIST_TARGETS = 3'd4,
        MODE_LIST_NODES   = 3'd5
    } t_mode;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_NODE   = 2'd1,
        ST_TARGET = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_LIST
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the input transaction
        logic scan_start;  // start a lookup walk over the key memory
        logic list_start;  // start a list walk over the selected bits
        logic list_all;    // list walk covers every used slot
        logic exec;        // apply the update and post the status result
        logic emit_empty;  // post the result of an empty list
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_list_all; // incoming mode lists all nodes
        logic in_scan;     // incoming mode needs a key lookup
        logic walk_done;   // walk over the slots has finished
        logic go_list;     // target list of a known node follows
        logic out_free;    // output register can take a result
        logic emitted;     // current list has produced at least one item
    } t_sts;

endpackage

>>> hw/rtl/dget_in_if.sv
// ----------------------------------------------------------------------------
// Operation channel
// Valid/ready channel that carries one operation per transaction.
// ----------------------------------------------------------------------------
interface dget_in_if import dget_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  node_key;
    logic [KEY_W-1:0]  target_key;

    modport source (output valid, output mode, output node_key, output target_key,
                    input ready);
    modport sink   (input valid, input mode, input node_key, input target_key,
                    output ready);
endinterface

>>> hw/rtl/dget_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
interface dget_out_if import dget_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    item_key;
    logic                has_item;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output item_key, output has_item, output status,
                    output last, input ready);
    modport sink   (input valid, input item_key, input has_item, input status,
                    input last, output ready);
endinterface

>>> hw/rtl/dget_ctrl.sv
// ----------------------------------------------------------------------------
// Edge table controller
// Sequences each operation: accept, key lookup walk, update, list walk.
// ----------------------------------------------------------------------------
module dget_ctrl import dget_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_sts   i_sts,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    if (i_sts.in_list_all) begin
                        n_state = S_LIST;
                    end else if (i_sts.in_scan) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.walk_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.go_list) begin
                    n_state = S_LIST;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_sts.walk_done && (i_sts.emitted || i_sts.out_free)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_list_all) begin
                        o_cmd.list_start = 1'b1;
                        o_cmd.list_all   = 1'b1;
                    end else if (i_sts.in_scan) begin
                        o_cmd.scan_start = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd = '0;
            end
            S_EXEC: begin
                if (i_sts.go_list) begin
                    o_cmd.list_start = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                end
            end
            S_LIST: begin
                if (i_sts.walk_done && !i_sts.emitted && i_sts.out_free) begin
                    o_cmd.emit_empty = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/dget_datapath.sv
// ----------------------------------------------------------------------------
// Edge table datapath
// Key memory, slot and edge flags, the slot walk pipeline, update logic
// and the result register.
// ----------------------------------------------------------------------------
module dget_datapath import dget_pkg::*; #(
    parameter int MAX_NODES = 16,
    parameter int KEY_BITS  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [KEY_W-1:0]    i_node_key,
    input  logic [KEY_W-1:0]    i_target_key,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [KEY_W-1:0]    o_item_key,
    output logic                o_has_item,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_last
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    // Captured operation.
    logic [MODE_W-1:0]    r_mode;
    logic [KEY_BITS-1:0]  r_a;
    logic [KEY_BITS-1:0]  r_b;

    // Table state.
    logic [KEY_BITS-1:0]  r_key_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_used;
    logic [MAX_NODES-1:0] r_edge [MAX_NODES];

    // Walk pipeline.
    logic                 r_walking;
    logic                 r_listing;
    logic                 r_qv;
    logic [CW-1:0]        r_idx;
    logic [IW-1:0]        r_qi;
    logic [KEY_BITS-1:0]  r_q;
    logic [MAX_NODES-1:0] r_bits;
    logic                 r_emitted;

    // Lookup results.
    logic                 r_a_hit;
    logic                 r_b_hit;
    logic                 r_free_hit;
    logic [IW-1:0]        r_a_slot;
    logic [IW-1:0]        r_b_slot;
    logic [IW-1:0]        r_free_slot;

    // Result register.
    logic                 r_ov;
    logic [KEY_W-1:0]     r_okey;
    logic                 r_ohas;
    logic [STATUS_W-1:0]  r_ostat;
    logic                 r_olast;

    logic                 idx_ok;
    logic                 need_emit;
    logic                 out_free;
    logic                 adv;
    logic                 cons;
    logic                 list_emit;
    logic                 list_last;
    logic                 q_used;
    logic                 a_eq;
    logic                 b_eq;
    t_status              x_st;
    logic                 x_add;
    logic                 x_rem_node;
    logic                 x_add_edge;
    logic                 x_rem_edge;

    // Capture the operation at the input transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_a    <= KEY_BITS'(i_node_key);
            r_b    <= KEY_BITS'(i_target_key);
        end
    end

    // Walk advance: a listed item waits until the result register frees up.
    assign idx_ok    = (r_idx < CW'(MAX_NODES));
    assign out_free  = !r_ov || i_out_ready;
    assign need_emit = r_listing && r_qv && r_bits[r_qi];
    assign adv       = r_walking && (!need_emit || out_free);
    assign cons      = adv && r_qv;
    assign list_emit = cons && need_emit;
    assign q_used    = r_used[r_qi];
    assign a_eq      = (r_q == r_a);
    assign b_eq      = (r_q == r_b);

    // The listed item is the last one when no selected bit lies above it.
    always_comb begin
        list_last = 1'b1;
        for (int j = 0; j < MAX_NODES; j++) begin
            if (r_bits[j] && (j > int'(r_qi))) begin
                list_last = 1'b0;
            end
        end
    end

    // Walk control and lookup flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walking  <= 1'b0;
            r_listing  <= 1'b0;
            r_qv       <= 1'b0;
            r_idx      <= '0;
            r_emitted  <= 1'b0;
            r_a_hit    <= 1'b0;
            r_b_hit    <= 1'b0;
            r_free_hit <= 1'b0;
        end else if (i_cmd.scan_start || i_cmd.list_start) begin
            r_walking <= 1'b1;
            r_listing <= i_cmd.list_start;
            r_qv      <= 1'b0;
            r_idx     <= '0;
            r_emitted <= 1'b0;
            if (i_cmd.scan_start) begin
                r_a_hit    <= 1'b0;
                r_b_hit    <= 1'b0;
                r_free_hit <= 1'b0;
            end
        end else if (adv) begin
            if (idx_ok) begin
                r_qv  <= 1'b1;
                r_idx <= r_idx + CW'(1);
            end else begin
                r_qv      <= 1'b0;
                r_walking <= 1'b0;
            end
            if (cons && !r_listing) begin
                if (q_used && a_eq) begin
                    r_a_hit <= 1'b1;
                end
                if (q_used && b_eq) begin
                    r_b_hit <= 1'b1;
                end
                if (!q_used) begin
                    r_free_hit <= 1'b1;
                end
            end
            if (list_emit) begin
                r_emitted <= 1'b1;
            end
        end
    end

    // Key memory read, lookup slots and list bits.
    always_ff @(posedge i_clk) begin
        if (adv && idx_ok) begin
            r_q  <= r_key_mem[r_idx[IW-1:0]];
            r_qi <= r_idx[IW-1:0];
        end
        if (cons && !r_listing) begin
            if (q_used && a_eq) begin
                r_a_slot <= r_qi;
            end
            if (q_used && b_eq) begin
                r_b_slot <= r_qi;
            end
            if (!q_used && !r_free_hit) begin
                r_free_slot <= r_qi;
            end
        end
        if (i_cmd.list_start) begin
            r_bits <= i_cmd.list_all ? r_used : r_edge[r_a_slot];
        end
    end

    // Update decision for the captured operation.
    always_comb begin
        x_st       = ST_DONE;
        x_add      = 1'b0;
        x_rem_node = 1'b0;
        x_add_edge = 1'b0;
        x_rem_edge = 1'b0;
        case (r_mode)
            MODE_ADD_NODE: begin
                if (r_a_hit) begin
                    x_st = ST_NODE;
                end else if (!r_free_hit) begin
                    x_st = ST_FULL;
                end else begin
                    x_add = 1'b1;
                end
            end
            MODE_REMOVE_NODE: begin
                if (!r_a_hit) begin
                    x_st = ST_NODE;
                end else begin
                    x_rem_node = 1'b1;
                end
            end
            MODE_ADD_EDGE: begin
                if (r_a == r_b) begin
                    x_st = ST_TARGET;
                end else if (!r_a_hit) begin
                    x_st = ST_NODE;
                end else if (!r_b_hit) begin
                    x_st = ST_TARGET;
                end else begin
                    x_add_edge = 1'b1;
                end
            end
            MODE_REMOVE_EDGE: begin
                if (!r_a_hit) begin
                    x_st = ST_NODE;
                end else if (!r_b_hit) begin
                    x_st = ST_TARGET;
                end else begin
                    x_rem_edge = 1'b1;
                end
            end
            MODE_LIST_TARGETS: begin
                x_st = r_a_hit ? ST_DONE : ST_NODE;
            end
            default: begin
                x_st = ST_DONE;
            end
        endcase
    end

    // Key memory write on a node add.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && x_add) begin
            r_key_mem[r_free_slot] <= r_a;
        end
    end

    // Slot flags and edge rows. Removing a node clears its row and column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            for (int i = 0; i < MAX_NODES; i++) begin
                r_edge[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (x_add) begin
                r_used[r_free_slot] <= 1'b1;
                r_edge[r_free_slot] <= '0;
            end
            if (x_rem_node) begin
                r_used[r_a_slot] <= 1'b0;
                for (int i = 0; i < MAX_NODES; i++) begin
                    if (IW'(i) == r_a_slot) begin
                        r_edge[i] <= '0;
                    end else begin
                        r_edge[i][r_a_slot] <= 1'b0;
                    end
                end
            end
            if (x_add_edge) begin
                r_edge[r_a_slot][r_b_slot] <= 1'b1;
            end
            if (x_rem_edge) begin
                r_edge[r_a_slot][r_b_slot] <= 1'b0;
            end
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (list_emit || i_cmd.exec || i_cmd.emit_empty) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (list_emit) begin
            r_okey  <= KEY_W'(r_q);
            r_ohas  <= 1'b1;
            r_ostat <= ST_DONE;
            r_olast <= list_last;
        end else if (i_cmd.exec) begin
            r_okey  <= '0;
            r_ohas  <= 1'b0;
            r_ostat <= x_st;
            r_olast <= 1'b1;
        end else if (i_cmd.emit_empty) begin
            r_okey  <= '0;
            r_ohas  <= 1'b0;
            r_ostat <= ST_DONE;
            r_olast <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_item_key  = r_okey;
    assign o_has_item  = r_ohas;
    assign o_status    = r_ostat;
    assign o_last      = r_olast;

    // Status toward the controller.
    always_comb begin
        o_sts.in_list_all = (i_mode == MODE_LIST_NODES);
        o_sts.in_scan     = i_mode inside {[MODE_ADD_NODE:MODE_LIST_TARGETS]};
        o_sts.walk_done   = !r_walking;
        o_sts.go_list     = (r_mode == MODE_LIST_TARGETS) && r_a_hit;
        o_sts.out_free    = out_free;
        o_sts.emitted     = r_emitted;
    end

endmodule

>>> hw/rtl/directed_graph_edge_table.sv
// ----------------------------------------------------------------------------
// Directed graph edge table
// Bounded table of node ids with a directed edge bit matrix. Nodes and edges
// are added and removed, and targets or nodes are listed in slot order.
//
//   Channel  Dir  Transaction
//   i_in     in   mode, node_key, target_key: one operation
//   o_res    out  item_key, has_item, status, last: one result
//
// Add, remove and edge operations first walk the single-port key memory to
// look up their keys, then apply the update and post their status once the
// result register is free. The next operation is taken back in idle.
// Listing all nodes runs only the list walk; listing targets runs the lookup
// walk first and then the list walk.
// Reset clears slot flags and edge rows; keys need no clearing.
// A stalled result register holds the list walk until the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module directed_graph_edge_table import dget_pkg::*; #(
    parameter int MAX_NODES = 16,
    parameter int KEY_BITS  = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dget_in_if.sink  i_in,
    dget_out_if.source o_res
);

    t_cmd cmd;
    t_sts sts;

    // Controller.
    dget_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    dget_datapath #(
        .MAX_NODES (MAX_NODES),
        .KEY_BITS  (KEY_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_in.mode),
        .i_node_key   (i_in.node_key),
        .i_target_key (i_in.target_key),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_item_key   (o_res.item_key),
        .o_has_item   (o_res.has_item),
        .o_status     (o_res.status),
        .o_last       (o_res.last)
    );

    // The block is busy in the cycle after it takes an operation.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "operation accepted while busy")
    // An update only posts its status into a free result register.
    `ASSERT_IMPLIES(a_exec_into_free, i_clk, i_rst_n, cmd.exec, sts.out_free, "status result overwrote a pending result")
    // A result without an item always closes its operation.
    `ASSERT_IMPLIES(a_empty_is_last, i_clk, i_rst_n, o_res.valid && !o_res.has_item, o_res.last, "status-only result not marked last")

endmodule
